// File: src/cpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

   localparam int LATENCY = 80;

   typedef struct packed {
      logic [23:0] distance;
      logic [23:0] radius_a;
      logic [23:0] radius_b;
      logic [23:0] repulsion_strength_a;
      logic [23:0] repulsion_strength_b;
      logic [23:0] adhesion_strength_a;
      logic [23:0] adhesion_strength_b;
      logic [15:0] reach_factor_a;
      logic [15:0] reach_factor_b;
   } req_type;

   typedef struct packed {
      logic signed [47:0] force_res;
      logic               degenerate;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/cpf_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_div_pipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 26,
   parameter int QW    = 48
) (
   input  wire logic             clock,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QW-1:0]    quo
);

   logic [DEN_W-1:0] rem_ff [QW];
   logic [DEN_W-1:0] den_ff [QW];
   logic [QW-1:0]    low_ff [QW];
   logic [QW-1:0]    q_ff   [QW];
   logic [DEN_W-1:0] rem0;

   generate
      if (NUM_W > QW) begin : g_upper
         assign rem0 = DEN_W'(num[NUM_W-1:QW]);
      end else begin : g_noupper
         assign rem0 = '0;
      end
   endgenerate

   genvar i;
   generate
      for (i = 0; i < QW; i++) begin : g_stage
         logic [DEN_W-1:0] rem_p;
         logic [DEN_W-1:0] den_p;
         logic [QW-1:0]    low_p;
         logic [QW-1:0]    q_p;
         logic [DEN_W:0]   rem2;
         logic             ge;
         if (i == 0) begin : g_first
            assign rem_p = rem0;
            assign den_p = den;
            assign low_p = num[QW-1:0];
            assign q_p   = '0;
         end else begin : g_next
            assign rem_p = rem_ff[i-1];
            assign den_p = den_ff[i-1];
            assign low_p = low_ff[i-1];
            assign q_p   = q_ff[i-1];
         end
         assign rem2 = {rem_p, low_p[QW-1]};
         assign ge   = rem2 >= {1'b0, den_p};
         always_ff @(posedge clock) begin
            rem_ff[i] <= ge ? DEN_W'(rem2 - {1'b0, den_p}) : rem2[DEN_W-1:0];
            den_ff[i] <= den_p;
            low_ff[i] <= {low_p[QW-2:0], 1'b0};
            q_ff[i]   <= {q_p[QW-2:0], ge};
         end
      end
   endgenerate

   assign quo = q_ff[QW-1];

endmodule

`default_nettype wire

// File: src/cpf_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_sqrt_pipe (
   input  wire logic        clock,
   input  wire logic [47:0] value,
   output logic      [23:0] root
);

   logic [47:0] v_ff [24];
   logic [47:0] r_ff [24];

   genvar k;
   generate
      for (k = 0; k < 24; k++) begin : g_stage
         localparam logic [47:0] BIT = 48'(1) << (46 - 2 * k);
         logic [47:0] v_p;
         logic [47:0] r_p;
         logic [47:0] t;
         if (k == 0) begin : g_first
            assign v_p = value;
            assign r_p = '0;
         end else begin : g_next
            assign v_p = v_ff[k-1];
            assign r_p = r_ff[k-1];
         end
         assign t = r_p + BIT;
         always_ff @(posedge clock) begin
            if (v_p >= t) begin
               v_ff[k] <= v_p - t;
               r_ff[k] <= (r_p >> 1) + BIT;
            end else begin
               v_ff[k] <= v_p;
               r_ff[k] <= r_p >> 1;
            end
         end
      end
   endgenerate

   assign root = r_ff[23][23:0];

endmodule

`default_nettype wire

// File: src/cell_pair_force_potential.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined cell pair force kernel. A request is taken in every cycle
// (busy stays low). Its result is shown on rsp with rsp_strobe, in request
// order. The latency is set by the 25-stage falloff divider, the 48-stage long
// division by the distance, and seven stages of multiply, compare and output
// register around them. The receiver cannot stall the block; every strobe must
// be taken when it is shown.

module cell_pair_force_potential (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire cpf_pkg::req_type req,
   output logic                 rsp_strobe,
   output cpf_pkg::rsp_type     rsp
);

   localparam int LAT = cpf_pkg::LATENCY;
   localparam int FQ  = 25;
   localparam int DQ  = 48;
   localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;

   logic [LAT-1:0] valid_ff;
   logic           accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], accept};
      end
   end

   // stage 1
   logic [23:0] d1_ff;
   logic [24:0] rs1_ff;
   logic [39:0] pfa1_ff, pfb1_ff;
   logic [47:0] pp1_ff, pa1_ff;

   always_ff @(posedge clock) begin
      d1_ff   <= req.distance;
      rs1_ff  <= {1'b0, req.radius_a} + {1'b0, req.radius_b};
      pfa1_ff <= req.reach_factor_a * req.radius_a;
      pfb1_ff <= req.reach_factor_b * req.radius_b;
      pp1_ff  <= req.repulsion_strength_a * req.repulsion_strength_b;
      pa1_ff  <= req.adhesion_strength_a * req.adhesion_strength_b;
   end

   // stage 2
   logic [23:0] d2_ff;
   logic [24:0] rs2_ff;
   logic [40:0] as2_ff;
   logic [47:0] pp2_ff, pa2_ff;

   always_ff @(posedge clock) begin
      d2_ff  <= d1_ff;
      rs2_ff <= rs1_ff;
      as2_ff <= {1'b0, pfa1_ff} + {1'b0, pfb1_ff};
      pp2_ff <= pp1_ff;
      pa2_ff <= pa1_ff;
   end

   // stage 3: falloff setup
   logic        rz, az;
   logic [40:0] dsh;
   assign dsh = {5'b0, d2_ff, 12'b0};
   assign rz  = (rs2_ff == '0) || ({1'b0, d2_ff} >= rs2_ff);
   assign az  = (as2_ff == '0) || (dsh >= as2_ff);

   logic [23:0] d3_ff;
   logic [24:0] rn3_ff, rd3_ff;
   logic [40:0] an3_ff, ad3_ff;
   logic        rz3_ff, az3_ff, dg3_ff;
   logic [47:0] pp3_ff, pa3_ff;

   always_ff @(posedge clock) begin
      d3_ff  <= d2_ff;
      rz3_ff <= rz;
      az3_ff <= az;
      dg3_ff <= (d2_ff == '0) || (rs2_ff == '0) || (as2_ff == '0);
      rn3_ff <= rz ? '0 : rs2_ff - {1'b0, d2_ff};
      rd3_ff <= rz ? 25'd1 : rs2_ff;
      an3_ff <= az ? '0 : as2_ff - dsh;
      ad3_ff <= az ? 41'd1 : as2_ff;
      pp3_ff <= pp2_ff;
      pa3_ff <= pa2_ff;
   end

   logic [FQ-1:0] f_rep, f_adh;
   logic [23:0]   c_rep, c_adh;

   cpf_div_pipe #(.NUM_W(49), .DEN_W(25), .QW(FQ)) u_frac_rep (
      .clock(clock), .num({rn3_ff, 24'b0}), .den(rd3_ff), .quo(f_rep)
   );

   cpf_div_pipe #(.NUM_W(65), .DEN_W(41), .QW(FQ)) u_frac_adh (
      .clock(clock), .num({an3_ff, 24'b0}), .den(ad3_ff), .quo(f_adh)
   );

   cpf_sqrt_pipe u_sqrt_rep (.clock(clock), .value(pp3_ff), .root(c_rep));
   cpf_sqrt_pipe u_sqrt_adh (.clock(clock), .value(pa3_ff), .root(c_adh));

   // side delays across the falloff divider
   logic [23:0] d_dly_ff  [FQ];
   logic        rz_dly_ff [FQ];
   logic        az_dly_ff [FQ];
   logic [23:0] cr28_ff, ca28_ff;

   always_ff @(posedge clock) begin
      d_dly_ff[0]  <= d3_ff;
      rz_dly_ff[0] <= rz3_ff;
      az_dly_ff[0] <= az3_ff;
      for (int i = 1; i < FQ; i++) begin
         d_dly_ff[i]  <= d_dly_ff[i-1];
         rz_dly_ff[i] <= rz_dly_ff[i-1];
         az_dly_ff[i] <= az_dly_ff[i-1];
      end
      cr28_ff <= c_rep;
      ca28_ff <= c_adh;
   end

   // square of falloff
   logic [49:0] fr_sq, fa_sq;
   assign fr_sq = f_rep * f_rep;
   assign fa_sq = f_adh * f_adh;

   logic [24:0] sr29_ff, sa29_ff;
   logic [23:0] cr29_ff, ca29_ff, d29_ff;

   always_ff @(posedge clock) begin
      sr29_ff <= rz_dly_ff[FQ-1] ? '0 : fr_sq[48:24];
      sa29_ff <= az_dly_ff[FQ-1] ? '0 : fa_sq[48:24];
      cr29_ff <= cr28_ff;
      ca29_ff <= ca28_ff;
      d29_ff  <= d_dly_ff[FQ-1];
   end

   // terms
   logic [48:0] tr_full, ta_full;
   assign tr_full = cr29_ff * sr29_ff;
   assign ta_full = ca29_ff * sa29_ff;

   logic [47:0] tr30_ff, ta30_ff;
   logic [23:0] d30_ff;

   always_ff @(posedge clock) begin
      tr30_ff <= tr_full[47:0];
      ta30_ff <= ta_full[47:0];
      d30_ff  <= d29_ff;
   end

   // net magnitude and sign
   logic [47:0] mag31_ff;
   logic [25:0] dv31_ff;
   logic        neg31_ff, dz31_ff;

   always_ff @(posedge clock) begin
      neg31_ff <= ta30_ff > tr30_ff;
      mag31_ff <= (ta30_ff > tr30_ff) ? ta30_ff - tr30_ff : tr30_ff - ta30_ff;
      dv31_ff  <= {d30_ff, 2'b00};
      dz31_ff  <= d30_ff == '0;
   end

   logic [DQ-1:0] quo;

   cpf_div_pipe #(.NUM_W(48), .DEN_W(26), .QW(DQ)) u_div_force (
      .clock(clock), .num(mag31_ff), .den(dv31_ff), .quo(quo)
   );

   logic neg_dly_ff [DQ];
   logic dz_dly_ff  [DQ];
   logic dg_dly_ff  [LAT-4];

   always_ff @(posedge clock) begin
      neg_dly_ff[0] <= neg31_ff;
      dz_dly_ff[0]  <= dz31_ff;
      for (int i = 1; i < DQ; i++) begin
         neg_dly_ff[i] <= neg_dly_ff[i-1];
         dz_dly_ff[i]  <= dz_dly_ff[i-1];
      end
      dg_dly_ff[0] <= dg3_ff;
      for (int i = 1; i < LAT - 4; i++) begin
         dg_dly_ff[i] <= dg_dly_ff[i-1];
      end
   end

   // saturate, apply sign, output register
   logic        neg_q;
   logic [47:0] mag_sat;
   assign neg_q   = neg_dly_ff[DQ-1];
   assign mag_sat = (quo > OUT_MAX) ? (neg_q ? OUT_MAX + 48'd1 : OUT_MAX) : quo;

   cpf_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.force_res  <= dz_dly_ff[DQ-1] ? '0 :
                           (neg_q ? -$signed(mag_sat) : $signed(mag_sat));
      rsp_ff.degenerate <= dg_dly_ff[LAT-5];
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = valid_ff[LAT-1];

endmodule

`default_nettype wire

// File: src/cpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_props (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire cpf_pkg::req_type req,
   input wire logic             rsp_strobe,
   input wire cpf_pkg::rsp_type rsp
);

   localparam int LAT = cpf_pkg::LATENCY;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_reset_clear : assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe after reset");

   a_strobe_has_request : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without request");

   a_zero_distance : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req.distance == 24'd0, LAT))
         |-> (rsp.force_res == 48'sd0 && rsp.degenerate))
      else $error("zero distance result wrong");

endmodule

bind cell_pair_force_potential cpf_props u_cpf_props (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
);

`default_nettype wire
